// ===== hw/rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg - shared definitions for the point-to-pixel projection unit
// Field widths, derived datapath widths, status and register codes, and
// the stage records that travel down the projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  // field widths
  localparam int COORD_BITS = 16;
  localparam int PIXEL_BITS = 12;
  localparam int COLOR_BITS = 8;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 3;
  localparam int FOCAL_W    = 16;
  localparam int SIZE_CFG_W = 13;
  localparam int DEPTH_W    = 15;

  // datapath widths
  localparam int PA_W    = COORD_BITS + 17;           // focal * coordinate
  localparam int PB_W    = COORD_BITS + 18;           // (centre + 8) * z
  localparam int NUM_W   = COORD_BITS + 18;           // numerator, signed
  localparam int MAG_W   = COORD_BITS - 1;            // magnitude of positive z
  localparam int D_W     = MAG_W + 4;                 // divisor 16*z
  localparam int REM_W   = MAG_W + PIXEL_BITS + 4;    // remainder, below d << PIXEL_BITS
  localparam int LIM_W   = (NUM_W - 1 > REM_W) ? NUM_W - 1 : REM_W;
  localparam int DEP_W   = (MAG_W > DEPTH_W) ? MAG_W : DEPTH_W;
  localparam int SIZE_W  = (PIXEL_BITS + 1 > SIZE_CFG_W) ? PIXEL_BITS + 1 : SIZE_CFG_W;

  // divider: two quotient bits per stage
  localparam int DIV_STAGES = (PIXEL_BITS + 1) / 2;
  localparam int QW         = 2 * DIV_STAGES;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_DEPTH   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X      = 3'd0,
    REG_FOCAL_Y      = 3'd1,
    REG_CENTRE_X     = 3'd2,
    REG_CENTRE_Y     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_DEPTH_LIMIT  = 3'd6
  } reg_index_t;

  // products stage record
  typedef struct packed {
    logic                  depth_fail;
    logic [PA_W-1:0]       fx_prod;
    logic [PA_W-1:0]       fy_prod;
    logic [PB_W-1:0]       cx_prod;
    logic [PB_W-1:0]       cy_prod;
    logic [MAG_W-1:0]      zmag;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } prod_stage_t;

  // divider stage record
  typedef struct packed {
    logic                  depth_fail;
    logic                  range_fail;
    logic [REM_W-1:0]      rem_x;
    logic [REM_W-1:0]      rem_y;
    logic [QW-1:0]         q_x;
    logic [QW-1:0]         q_y;
    logic [D_W-1:0]        d;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } div_stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppp_if.sv =====
// ----------------------------------------------------------------------------
// ppp_if - stream channels of the point-to-pixel projection unit
// point_if carries one colored 3-D point, pixel_if one projection result.
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface point_if import ppp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [COLOR_BITS-1:0]        red_in;
  logic [COLOR_BITS-1:0]        green_in;
  logic [COLOR_BITS-1:0]        blue_in;

  modport source (
    output valid, point_x, point_y, point_z, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, red_in, green_in, blue_in,
    output ready
  );
endinterface

interface pixel_if import ppp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [PIXEL_BITS-1:0] pixel_row;
  logic [PIXEL_BITS-1:0] pixel_col;
  logic [COLOR_BITS-1:0] red_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] blue_out;

  modport source (
    output valid, status, pixel_row, pixel_col, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, status, pixel_row, pixel_col, red_out, green_out, blue_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/point_to_pixel_projection_unit.sv =====
// ----------------------------------------------------------------------------
// point_to_pixel_projection_unit - pinhole projection of colored points
// Projects camera-frame points onto image pixels and reports hit, depth
// reject or outside-image, with the address and color for a frame store.
// ----------------------------------------------------------------------------
// Usage:
//   point  : input stream, one 3-D point (mm) plus RGB color per transfer.
//   pixel  : output stream, one result per point: status, row, col, color.
//   cfg_*  : write port for the intrinsics, image size and depth limit;
//            write only while no point is in flight.
// Timing:
//   One point per cycle sustained while the receiver keeps pixel.ready
//   high. A point passes through one stage of multipliers, one numerator
//   add with range check, DIV_STAGES restoring divider stages at two
//   quotient bits each, and one output stage.
// Flow control:
//   Every stage has its own valid bit and loads when it is empty or the
//   stage after it moves, so bubbles close up and input keeps being taken
//   while the result register waits. A receiver stall holds every full
//   stage; nothing is dropped or repeated.
// Reset:
//   rst empties the pipeline and restores the default intrinsics, image size and depth limit.
// ----------------------------------------------------------------------------
`default_nettype none

module point_to_pixel_projection_unit import ppp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  point_if.sink                 point,
  pixel_if.source               pixel,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem,
                                              logic [REM_W-1:0] dsh);
    logic [REM_W:0] diff;
    diff = {1'b0, rem} - {1'b0, dsh};
    if (diff[REM_W]) begin
      div_step = {1'b0, rem};
    end else begin
      div_step = {1'b1, diff[REM_W-1:0]};
    end
  endfunction

  // configuration registers
  logic [FOCAL_W-1:0]    focal_x;
  logic [FOCAL_W-1:0]    focal_y;
  logic [FOCAL_W-1:0]    centre_x;
  logic [FOCAL_W-1:0]    centre_y;
  logic [SIZE_CFG_W-1:0] image_width;
  logic [SIZE_CFG_W-1:0] image_height;
  logic [DEPTH_W-1:0]    depth_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= FOCAL_W'(8400);
      focal_y      <= FOCAL_W'(8400);
      centre_x     <= FOCAL_W'(5112);
      centre_y     <= FOCAL_W'(3832);
      image_width  <= SIZE_CFG_W'(640);
      image_height <= SIZE_CFG_W'(480);
      depth_limit  <= DEPTH_W'(1000);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FOCAL_X:      focal_x      <= cfg_data[FOCAL_W-1:0];
        REG_FOCAL_Y:      focal_y      <= cfg_data[FOCAL_W-1:0];
        REG_CENTRE_X:     centre_x     <= cfg_data[FOCAL_W-1:0];
        REG_CENTRE_Y:     centre_y     <= cfg_data[FOCAL_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_CFG_W-1:0];
        REG_DEPTH_LIMIT:  depth_limit  <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  logic en_out;
  logic en_prod;
  logic en_div [0:DIV_STAGES];
  logic v_prod;
  logic v_div  [0:DIV_STAGES];
  logic o_valid;

  assign en_out              = !o_valid || pixel.ready;
  assign en_div[DIV_STAGES]  = !v_div[DIV_STAGES] || en_out;
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_en
    assign en_div[k] = !v_div[k] || en_div[k+1];
  end
  assign en_prod     = !v_prod || en_div[0];
  assign point.ready = en_prod;

  // stage 1: depth test and the four products
  prod_stage_t         prod_next;
  prod_stage_t         prod;
  logic signed [PA_W-1:0] fx_mul, fy_mul;
  logic signed [PB_W-1:0] cx_mul, cy_mul;
  logic                z_pos, z_near;

  always_comb begin
    fx_mul = $signed({1'b0, focal_x}) * point.point_x;
    fy_mul = $signed({1'b0, focal_y}) * point.point_y;
    cx_mul = $signed({2'b00, centre_x} + 18'd8) * point.point_z;
    cy_mul = $signed({2'b00, centre_y} + 18'd8) * point.point_z;
    z_pos  = !point.point_z[COORD_BITS-1] && (point.point_z != '0);
    z_near = DEP_W'(point.point_z[COORD_BITS-2:0]) < DEP_W'(depth_limit);

    prod_next.depth_fail = !(z_pos && z_near);
    prod_next.fx_prod    = fx_mul;
    prod_next.fy_prod    = fy_mul;
    prod_next.cx_prod    = cx_mul;
    prod_next.cy_prod    = cy_mul;
    prod_next.zmag       = point.point_z[COORD_BITS-2:0];
    prod_next.red        = point.red_in;
    prod_next.green      = point.green_in;
    prod_next.blue       = point.blue_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod <= 1'b0;
    end else if (en_prod) begin
      v_prod <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod <= prod_next;
    end
  end

  // stage 2: numerators, sign and quotient-range check, divisor
  div_stage_t             stg [0:DIV_STAGES];
  div_stage_t             stg0_next;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [LIM_W-1:0]       lim;
  logic                   ovf_x, ovf_y;

  always_comb begin
    num_x = $signed(prod.fx_prod) + $signed(prod.cx_prod);
    num_y = $signed(prod.fy_prod) + $signed(prod.cy_prod);
    // quotient fits PIXEL_BITS only when num < z << (PIXEL_BITS + 4)
    lim   = LIM_W'({prod.zmag, {(PIXEL_BITS + 4){1'b0}}});
    ovf_x = num_x[NUM_W-1] || (LIM_W'(num_x[NUM_W-2:0]) >= lim);
    ovf_y = num_y[NUM_W-1] || (LIM_W'(num_y[NUM_W-2:0]) >= lim);

    stg0_next.depth_fail = prod.depth_fail;
    stg0_next.range_fail = ovf_x || ovf_y;
    stg0_next.rem_x      = REM_W'(num_x[NUM_W-2:0]);
    stg0_next.rem_y      = REM_W'(num_y[NUM_W-2:0]);
    stg0_next.q_x        = '0;
    stg0_next.q_y        = '0;
    stg0_next.d          = {prod.zmag, 4'b0000};
    stg0_next.red        = prod.red;
    stg0_next.green      = prod.green;
    stg0_next.blue       = prod.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_div[0] <= 1'b0;
    end else if (en_div[0]) begin
      v_div[0] <= v_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en_div[0]) begin
      stg[0] <= stg0_next;
    end
  end

  // divider stages, two quotient bits each, MSB first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int B_HI = QW - 1 - 2 * s;
    localparam int B_LO = B_HI - 1;

    div_stage_t       nxt;
    logic [REM_W-1:0] d_hi, d_lo;
    logic [REM_W:0]   sx_hi, sy_hi, sx_lo, sy_lo;

    always_comb begin
      d_hi  = REM_W'(stg[s].d) << B_HI;
      d_lo  = REM_W'(stg[s].d) << B_LO;
      sx_hi = div_step(stg[s].rem_x, d_hi);
      sy_hi = div_step(stg[s].rem_y, d_hi);
      sx_lo = div_step(sx_hi[REM_W-1:0], d_lo);
      sy_lo = div_step(sy_hi[REM_W-1:0], d_lo);

      nxt            = stg[s];
      nxt.rem_x      = sx_lo[REM_W-1:0];
      nxt.rem_y      = sy_lo[REM_W-1:0];
      nxt.q_x[B_HI]  = sx_hi[REM_W];
      nxt.q_x[B_LO]  = sx_lo[REM_W];
      nxt.q_y[B_HI]  = sy_hi[REM_W];
      nxt.q_y[B_LO]  = sy_lo[REM_W];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_div[s+1] <= 1'b0;
      end else if (en_div[s+1]) begin
        v_div[s+1] <= v_div[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en_div[s+1]) begin
        stg[s+1] <= nxt;
      end
    end
  end

  // output stage: image bounds, status, zeroed fields on a miss
  logic [PIXEL_BITS-1:0] col_q, row_q;
  logic                  in_image;
  status_t               status_next;
  logic [1:0]            o_status;
  logic [PIXEL_BITS-1:0] o_row, o_col;
  logic [COLOR_BITS-1:0] o_red, o_green, o_blue;

  always_comb begin
    col_q    = stg[DIV_STAGES].q_x[PIXEL_BITS-1:0];
    row_q    = stg[DIV_STAGES].q_y[PIXEL_BITS-1:0];
    in_image = !stg[DIV_STAGES].range_fail
               && (SIZE_W'(col_q) < SIZE_W'(image_width))
               && (SIZE_W'(row_q) < SIZE_W'(image_height));
    if (stg[DIV_STAGES].depth_fail) begin
      status_next = ST_DEPTH;
    end else if (!in_image) begin
      status_next = ST_OUTSIDE;
    end else begin
      status_next = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en_out) begin
      o_valid <= v_div[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      o_status <= status_next;
      if (status_next == ST_HIT) begin
        o_row   <= row_q;
        o_col   <= col_q;
        o_red   <= stg[DIV_STAGES].red;
        o_green <= stg[DIV_STAGES].green;
        o_blue  <= stg[DIV_STAGES].blue;
      end else begin
        o_row   <= '0;
        o_col   <= '0;
        o_red   <= '0;
        o_green <= '0;
        o_blue  <= '0;
      end
    end
  end

  assign pixel.valid     = o_valid;
  assign pixel.status    = o_status;
  assign pixel.pixel_row = o_row;
  assign pixel.pixel_col = o_col;
  assign pixel.red_out   = o_red;
  assign pixel.green_out = o_green;
  assign pixel.blue_out  = o_blue;

endmodule

`default_nettype wire

// ===== hw/rtl/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker - port-level checks for the projection unit
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_checker import ppp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            status,
  input wire logic [PIXEL_BITS-1:0] pixel_row,
  input wire logic [PIXEL_BITS-1:0] pixel_col,
  input wire logic [COLOR_BITS-1:0] red_out,
  input wire logic [COLOR_BITS-1:0] green_out,
  input wire logic [COLOR_BITS-1:0] blue_out
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(pixel_row)
      && $stable(pixel_col) && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("result payload changed while stalled");

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_HIT || status == ST_DEPTH || status == ST_OUTSIDE))
    else $error("illegal status code");

  // a miss carries zero address and color
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT |-> pixel_row == '0 && pixel_col == '0
      && red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("miss with nonzero fields");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind point_to_pixel_projection_unit ppp_checker u_ppp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .status    (pixel.status),
  .pixel_row (pixel.pixel_row),
  .pixel_col (pixel.pixel_col),
  .red_out   (pixel.red_out),
  .green_out (pixel.green_out),
  .blue_out  (pixel.blue_out)
);

`default_nettype wire
